@@ design/lteb_pkg.sv @@
// Shared constants, key codes, command and status types for the line text edit buffer.
// Used by lteb_ctrl, lteb_dpath and line_text_edit_buffer; depends on nothing.
package lteb_pkg;

    localparam int LINE_WIDTH = 80;
    localparam int MAX_LINES  = 256;
    localparam int VIEW_LINES = 25;

    localparam int ROW_W     = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int LEN_W     = $clog2(LINE_WIDTH + 1);
    localparam int TXT_DEPTH = MAX_LINES * LINE_WIDTH;
    localparam int PTR_W     = $clog2(TXT_DEPTH);

    localparam logic [15:0] KEY_BS     = 16'h0008;
    localparam logic [15:0] KEY_ENTER  = 16'h000D;
    localparam logic [15:0] KEY_SPACE  = 16'h0020;
    localparam logic [15:0] KEY_RUBOUT = 16'h007F;
    localparam logic [15:0] KEY_UP     = 16'h0101;
    localparam logic [15:0] KEY_DOWN   = 16'h0102;
    localparam logic [15:0] KEY_LEFT   = 16'h0103;
    localparam logic [15:0] KEY_RIGHT  = 16'h0104;
    localparam logic [15:0] KEY_HOME   = 16'h0105;
    localparam logic [15:0] KEY_END    = 16'h0106;
    localparam logic [15:0] KEY_DEL    = 16'h0107;

    typedef enum logic [3:0] {
        K_NONE, K_PUT, K_ENTER, K_BS, K_DEL, K_UP, K_DOWN, K_LEFT, K_RIGHT, K_HOME, K_END
    } kind_t;

    typedef enum logic [5:0] {
        C_NOP, C_CAPT, C_RDL_CUR, C_RDL_ROWM1, C_RDL_ROWP1, C_RDL_SRC, C_RDL_READ,
        C_RD_CAPT, C_GET_A, C_GET_B, C_INS_SETUP, C_INS_FIN, C_MV_RD, C_MV_WR,
        C_SPL_SETUP, C_LC_SETUP, C_LC_FIN, C_SPL_TAIL, C_SPL_FIN1, C_SPL_FIN2,
        C_BSD_SETUP, C_DLD_SETUP, C_DROP_FIN_BS, C_DROP_FIN_DEL, C_JBS_SETUP,
        C_JDEL_SETUP, C_APP_SETUP, C_APP_FIN, C_JOIN_FIN_BS, C_JOIN_FIN_DEL,
        C_ROW_DEC, C_ROW_INC, C_CLAMP, C_SET_COL_LEN, C_COL_DEC, C_COL_INC,
        C_ROW_INC_COL0, C_COL_ZERO, C_COL_LA, C_FOLLOW, C_OUT
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  is_read;
        logic  la_full;
        logic  lines_full;
        logic  n_zero;
        logic  spl_more;
        logic  gap_more;
        logic  col_gt0;
        logic  row_gt0;
        logic  col_lt_la;
        logic  row_next;
    } status_t;

    // Flat text store address of a row and column.
    function automatic logic [PTR_W-1:0] flat(input logic [CNT_W-1:0] r,
                                              input logic [LEN_W-1:0] c);
        return PTR_W'(int'(r) * LINE_WIDTH + int'(c));
    endfunction

    function automatic kind_t classify(input logic [15:0] k);
        kind_t res;
        case (k)
            KEY_ENTER: res = K_ENTER;
            KEY_BS:    res = K_BS;
            KEY_DEL:   res = K_DEL;
            KEY_UP:    res = K_UP;
            KEY_DOWN:  res = K_DOWN;
            KEY_LEFT:  res = K_LEFT;
            KEY_RIGHT: res = K_RIGHT;
            KEY_HOME:  res = K_HOME;
            KEY_END:   res = K_END;
            default:   res = (k >= KEY_SPACE && k != KEY_RUBOUT) ? K_PUT : K_NONE;
        endcase
        return res;
    endfunction

endpackage

@@ design/line_text_edit_buffer.sv @@
// Top level of the line text edit buffer: sequencer plus datapath.
// Depends on lteb_pkg, lteb_ctrl and lteb_dpath.

// The block holds up to 256 lines of up to 80 sixteen-bit characters, a cursor and a
// scroll top, and takes one item at a time. A key item (mode 0) edits or moves the
// cursor; a read item (mode 1) returns the character and length at a row and column.
// Every item gives exactly one result. Each character moved passes through the text
// memory as a registered read, then a write; an insert moves the characters right of
// the cursor, and a line split or join moves characters and shifts whole lines. A new
// item may be accepted while the previous result still waits in the output register.
// No clearing pass follows reset: line lengths carry one valid bit each, and text
// store contents at or beyond a line's length are never used.
module line_text_edit_buffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_key,
    input  logic [7:0]  s_read_row,
    input  logic [6:0]  s_read_col,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col,
    output logic [8:0]  m_line_count,
    output logic [6:0]  m_current_len,
    output logic [7:0]  m_scroll_top,
    output logic [15:0] m_read_char,
    output logic [6:0]  m_read_len
);

    lteb_pkg::cmd_t    cmd;
    lteb_pkg::status_t status;

    // The sequencer owns both handshakes; the datapath only executes commands.
    lteb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lteb_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .s_read_row    (s_read_row),
        .s_read_col    (s_read_col),
        .m_cursor_row  (m_cursor_row),
        .m_cursor_col  (m_cursor_col),
        .m_line_count  (m_line_count),
        .m_current_len (m_current_len),
        .m_scroll_top  (m_scroll_top),
        .m_read_char   (m_read_char),
        .m_read_len    (m_read_len)
    );

endmodule

@@ design/lteb_dpath.sv @@
// Datapath of the line text edit buffer: text and length memories, cursor registers,
// copy pointers and result registers. Depends on lteb_pkg; driven by lteb_ctrl commands.
module lteb_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lteb_pkg::cmd_t         cmd,
    output lteb_pkg::status_t      status,
    input  logic                   s_mode,
    input  logic [15:0]            s_key,
    input  logic [7:0]             s_read_row,
    input  logic [6:0]             s_read_col,
    output logic [7:0]             m_cursor_row,
    output logic [6:0]             m_cursor_col,
    output logic [8:0]             m_line_count,
    output logic [6:0]             m_current_len,
    output logic [7:0]             m_scroll_top,
    output logic [15:0]            m_read_char,
    output logic [6:0]             m_read_len
);

    localparam int RW = lteb_pkg::ROW_W;
    localparam int CW = lteb_pkg::CNT_W;
    localparam int LW = lteb_pkg::LEN_W;
    localparam int PW = lteb_pkg::PTR_W;

    logic [15:0] tmem [lteb_pkg::TXT_DEPTH];
    logic [LW-1:0] lmem [lteb_pkg::MAX_LINES];
    logic [lteb_pkg::MAX_LINES-1:0] lvalid_reg;

    logic [RW-1:0] row_reg, top_reg, jd_reg, in_rrow_reg;
    logic [LW-1:0] col_reg, la_reg, lb_reg, lc_reg, n_reg, jbase_reg, jadd_reg, in_rcol_reg;
    logic [CW-1:0] lines_reg, rd_reg;
    logic [PW-1:0] sptr_reg, dptr_reg;
    logic          up_reg, dir_reg, in_mode_reg, lvq_reg;
    logic [15:0]   in_key_reg, chr_q_reg, rchar_reg;
    logic [LW-1:0] lq_reg, rlen_reg;
    lteb_pkg::kind_t kind_reg;

    logic [LW-1:0] len_eff, room, app_n;
    logic [LW:0]   app_sum;
    logic [CW-1:0] row_ext, src_row;
    logic [CW:0]   f_row, f_t1, f_t2, f_lim, f_top;
    logic          lw_en, tw_en, rd_hit;
    logic [RW-1:0] lw_addr, lr_addr;
    logic [LW-1:0] lw_data;
    logic [PW-1:0] tw_addr, tr_addr;
    logic [15:0]   tw_data;

    assign len_eff = lvq_reg ? lq_reg : '0;
    assign row_ext = CW'(row_reg);
    assign src_row = up_reg ? rd_reg + CW'(1) : rd_reg - CW'(1);
    assign room    = LW'(lteb_pkg::LINE_WIDTH) - jbase_reg;
    assign app_n   = (jadd_reg < room) ? jadd_reg : room;
    assign app_sum = (LW + 1)'(jbase_reg) + (LW + 1)'(jadd_reg);
    assign rd_hit  = CW'(in_rrow_reg) < lines_reg;

    // Scroll window follow: bring the cursor row into view, then clamp to the text.
    always_comb begin
        f_row = (CW + 1)'(row_reg);
        f_t1  = (f_row < (CW + 1)'(top_reg)) ? f_row : (CW + 1)'(top_reg);
        f_t2  = (f_row >= f_t1 + (CW + 1)'(lteb_pkg::VIEW_LINES))
              ? f_row - (CW + 1)'(lteb_pkg::VIEW_LINES) + (CW + 1)'(1) : f_t1;
        f_lim = ((CW + 1)'(lines_reg) > (CW + 1)'(lteb_pkg::VIEW_LINES))
              ? (CW + 1)'(lines_reg) - (CW + 1)'(lteb_pkg::VIEW_LINES) : '0;
        f_top = (f_t2 > f_lim) ? f_lim : f_t2;
    end

    always_comb begin
        status.kind       = kind_reg;
        status.is_read    = in_mode_reg;
        status.la_full    = la_reg >= LW'(lteb_pkg::LINE_WIDTH);
        status.lines_full = lines_reg >= CW'(lteb_pkg::MAX_LINES);
        status.n_zero     = n_reg == '0;
        status.spl_more   = rd_reg > row_ext + CW'(1);
        status.gap_more   = rd_reg + CW'(1) < lines_reg;
        status.col_gt0    = col_reg != '0;
        status.row_gt0    = row_reg != '0;
        status.col_lt_la  = col_reg < la_reg;
        status.row_next   = row_ext + CW'(1) < lines_reg;
    end

    always_comb begin
        unique case (cmd)
            lteb_pkg::C_RDL_ROWM1: lr_addr = row_reg - RW'(1);
            lteb_pkg::C_RDL_ROWP1: lr_addr = row_reg + RW'(1);
            lteb_pkg::C_RDL_SRC:   lr_addr = src_row[RW-1:0];
            lteb_pkg::C_RDL_READ:  lr_addr = in_rrow_reg;
            default:               lr_addr = row_reg;
        endcase
    end

    always_comb begin
        lw_en   = 1'b1;
        lw_addr = row_reg;
        lw_data = la_reg - LW'(1);
        unique case (cmd)
            lteb_pkg::C_INS_FIN:      lw_data = la_reg + LW'(1);
            lteb_pkg::C_LC_FIN: begin
                lw_addr = rd_reg[RW-1:0];
                lw_data = lc_reg;
            end
            lteb_pkg::C_SPL_FIN1: begin
                lw_addr = row_reg + RW'(1);
                lw_data = la_reg - col_reg;
            end
            lteb_pkg::C_SPL_FIN2:     lw_data = col_reg;
            lteb_pkg::C_DROP_FIN_BS,
            lteb_pkg::C_DROP_FIN_DEL: lw_data = la_reg - LW'(1);
            lteb_pkg::C_APP_FIN: begin
                lw_addr = jd_reg;
                lw_data = (app_sum < (LW + 1)'(lteb_pkg::LINE_WIDTH))
                        ? app_sum[LW-1:0] : LW'(lteb_pkg::LINE_WIDTH);
            end
            default:                  lw_en = 1'b0;
        endcase
    end

    assign tw_en   = (cmd == lteb_pkg::C_MV_WR) || (cmd == lteb_pkg::C_INS_FIN);
    assign tw_addr = (cmd == lteb_pkg::C_INS_FIN) ? lteb_pkg::flat(row_ext, col_reg) : dptr_reg;
    assign tw_data = (cmd == lteb_pkg::C_INS_FIN) ? in_key_reg : chr_q_reg;
    assign tr_addr = (cmd == lteb_pkg::C_RDL_READ)
                   ? lteb_pkg::flat(CW'(in_rrow_reg), in_rcol_reg) : sptr_reg;

    always_ff @(posedge aclk) begin
        if (tw_en) begin
            tmem[tw_addr] <= tw_data;
        end
        chr_q_reg <= tmem[tr_addr];
    end

    always_ff @(posedge aclk) begin
        if (lw_en) begin
            lmem[lw_addr] <= lw_data;
        end
        lq_reg <= lmem[lr_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvalid_reg <= '0;
            lvq_reg    <= 1'b0;
        end else begin
            if (lw_en) begin
                lvalid_reg[lw_addr] <= 1'b1;
            end
            lvq_reg <= lvalid_reg[lr_addr];
        end
    end

    // Cursor, line count and scroll top.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            lines_reg <= CW'(1);
            top_reg   <= '0;
        end else begin
            case (cmd)
                lteb_pkg::C_INS_FIN:      col_reg <= col_reg + LW'(1);
                lteb_pkg::C_SPL_FIN2: begin
                    lines_reg <= lines_reg + CW'(1);
                    row_reg   <= row_reg + RW'(1);
                    col_reg   <= '0;
                end
                lteb_pkg::C_DROP_FIN_BS:  col_reg <= col_reg - LW'(1);
                lteb_pkg::C_JOIN_FIN_BS: begin
                    lines_reg <= lines_reg - CW'(1);
                    row_reg   <= row_reg - RW'(1);
                    col_reg   <= lb_reg;
                end
                lteb_pkg::C_JOIN_FIN_DEL: lines_reg <= lines_reg - CW'(1);
                lteb_pkg::C_ROW_DEC:      row_reg <= row_reg - RW'(1);
                lteb_pkg::C_ROW_INC:      row_reg <= row_reg + RW'(1);
                lteb_pkg::C_CLAMP:        col_reg <= (col_reg > len_eff) ? len_eff : col_reg;
                lteb_pkg::C_SET_COL_LEN:  col_reg <= len_eff;
                lteb_pkg::C_COL_DEC:      col_reg <= col_reg - LW'(1);
                lteb_pkg::C_COL_INC:      col_reg <= col_reg + LW'(1);
                lteb_pkg::C_ROW_INC_COL0: begin
                    row_reg <= row_reg + RW'(1);
                    col_reg <= '0;
                end
                lteb_pkg::C_COL_ZERO:     col_reg <= '0;
                lteb_pkg::C_COL_LA:       col_reg <= la_reg;
                lteb_pkg::C_FOLLOW:       top_reg <= f_top[RW-1:0];
                default: ;
            endcase
        end
    end

    // Working registers and results.
    always_ff @(posedge aclk) begin
        case (cmd)
            lteb_pkg::C_CAPT: begin
                in_mode_reg <= s_mode;
                in_key_reg  <= s_key;
                in_rrow_reg <= s_read_row;
                in_rcol_reg <= s_read_col;
                kind_reg    <= lteb_pkg::classify(s_key);
                rchar_reg   <= '0;
                rlen_reg    <= '0;
            end
            lteb_pkg::C_RD_CAPT: begin
                rlen_reg  <= rd_hit ? len_eff : '0;
                rchar_reg <= (rd_hit && LW'(in_rcol_reg) < len_eff) ? chr_q_reg : '0;
            end
            lteb_pkg::C_GET_A: la_reg <= len_eff;
            lteb_pkg::C_GET_B: lb_reg <= len_eff;
            lteb_pkg::C_INS_SETUP: begin
                sptr_reg <= lteb_pkg::flat(row_ext, la_reg - LW'(1));
                dptr_reg <= lteb_pkg::flat(row_ext, la_reg);
                n_reg    <= la_reg - col_reg;
                dir_reg  <= 1'b0;
            end
            lteb_pkg::C_MV_WR: begin
                sptr_reg <= dir_reg ? sptr_reg + PW'(1) : sptr_reg - PW'(1);
                dptr_reg <= dir_reg ? dptr_reg + PW'(1) : dptr_reg - PW'(1);
                n_reg    <= n_reg - LW'(1);
            end
            lteb_pkg::C_SPL_SETUP: begin
                rd_reg <= lines_reg;
                up_reg <= 1'b0;
            end
            lteb_pkg::C_LC_SETUP: begin
                lc_reg   <= len_eff;
                n_reg    <= len_eff;
                sptr_reg <= lteb_pkg::flat(src_row, '0);
                dptr_reg <= lteb_pkg::flat(rd_reg, '0);
                dir_reg  <= 1'b1;
            end
            lteb_pkg::C_LC_FIN: rd_reg <= src_row;
            lteb_pkg::C_SPL_TAIL: begin
                sptr_reg <= lteb_pkg::flat(row_ext, col_reg);
                dptr_reg <= lteb_pkg::flat(row_ext + CW'(1), '0);
                n_reg    <= la_reg - col_reg;
                dir_reg  <= 1'b1;
            end
            lteb_pkg::C_BSD_SETUP: begin
                sptr_reg <= lteb_pkg::flat(row_ext, col_reg);
                dptr_reg <= lteb_pkg::flat(row_ext, col_reg - LW'(1));
                n_reg    <= la_reg - col_reg;
                dir_reg  <= 1'b1;
            end
            lteb_pkg::C_DLD_SETUP: begin
                sptr_reg <= lteb_pkg::flat(row_ext, col_reg + LW'(1));
                dptr_reg <= lteb_pkg::flat(row_ext, col_reg);
                n_reg    <= la_reg - col_reg - LW'(1);
                dir_reg  <= 1'b1;
            end
            lteb_pkg::C_JBS_SETUP: begin
                jd_reg    <= row_reg - RW'(1);
                jbase_reg <= lb_reg;
                jadd_reg  <= la_reg;
            end
            lteb_pkg::C_JDEL_SETUP: begin
                jd_reg    <= row_reg;
                jbase_reg <= la_reg;
                jadd_reg  <= lb_reg;
            end
            lteb_pkg::C_APP_SETUP: begin
                sptr_reg <= lteb_pkg::flat(CW'(jd_reg) + CW'(1), '0);
                dptr_reg <= lteb_pkg::flat(CW'(jd_reg), jbase_reg);
                n_reg    <= app_n;
                dir_reg  <= 1'b1;
            end
            lteb_pkg::C_APP_FIN: begin
                rd_reg <= CW'(jd_reg) + CW'(1);
                up_reg <= 1'b1;
            end
            lteb_pkg::C_OUT: begin
                m_cursor_row  <= row_reg;
                m_cursor_col  <= col_reg;
                m_line_count  <= lines_reg;
                m_current_len <= len_eff;
                m_scroll_top  <= top_reg;
                m_read_char   <= rchar_reg;
                m_read_len    <= rlen_reg;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_row_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        row_ext < lines_reg) else $error("cursor row beyond line count");
    a_lines_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lines_reg != '0 && lines_reg <= CW'(lteb_pkg::MAX_LINES))
        else $error("line count out of range");
    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == lteb_pkg::C_OUT |=> m_cursor_col <= m_current_len)
        else $error("cursor column beyond line length");
`endif

endmodule

@@ design/lteb_ctrl.sv @@
// Sequencer of the line text edit buffer: handshakes and per-key command sequences.
// Depends on lteb_pkg; drives lteb_dpath through cmd and reads its status.
module lteb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  lteb_pkg::status_t status,
    output lteb_pkg::cmd_t    cmd
);

    localparam logic [5:0] S_IDLE = 6'd0, S_DISP0 = 6'd1, S_RDCAP = 6'd2, S_GETA = 6'd3,
        S_KEY = 6'd4, S_RDC_CLAMP = 6'd5, S_CLAMP = 6'd6, S_RDC_SETCOL = 6'd7,
        S_SETCOL = 6'd8, S_INS_SET = 6'd9, S_MV_CHK = 6'd10, S_MV_WR = 6'd11,
        S_INS_FIN = 6'd12, S_SPL_SET = 6'd13, S_SPL_CHK = 6'd14, S_LC_RD = 6'd15,
        S_LC_SET = 6'd16, S_LC_FIN = 6'd17, S_SPL_TAIL = 6'd18, S_SPL_F1 = 6'd19,
        S_SPL_F2 = 6'd20, S_BSD_SET = 6'd21, S_BSD_FIN = 6'd22, S_DLD_SET = 6'd23,
        S_DLD_FIN = 6'd24, S_GETB_BS = 6'd25, S_JBS = 6'd26, S_GETB_DEL = 6'd27,
        S_JDEL = 6'd28, S_APP_SET = 6'd29, S_APP_FIN = 6'd30, S_GAP_CHK = 6'd31,
        S_JFIN = 6'd32, S_FOLLOW = 6'd33, S_FIN = 6'd34, S_OUT = 6'd35;

    logic [5:0] st_reg, st_next, ret_reg, ret_next, lcr_reg, lcr_next;
    logic       mv_reg, mv_next;

    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = mv_reg;

    always_comb begin
        cmd      = lteb_pkg::C_NOP;
        st_next  = st_reg;
        ret_next = ret_reg;
        lcr_next = lcr_reg;
        unique case (st_reg)
            S_IDLE: if (s_valid) begin
                cmd     = lteb_pkg::C_CAPT;
                st_next = S_DISP0;
            end
            S_DISP0: begin
                cmd     = status.is_read ? lteb_pkg::C_RDL_READ : lteb_pkg::C_RDL_CUR;
                st_next = status.is_read ? S_RDCAP : S_GETA;
            end
            S_RDCAP: begin
                cmd     = lteb_pkg::C_RD_CAPT;
                st_next = S_FIN;
            end
            S_GETA: begin
                cmd     = lteb_pkg::C_GET_A;
                st_next = S_KEY;
            end
            S_KEY: begin
                st_next = S_FOLLOW;
                case (status.kind)
                    lteb_pkg::K_PUT:   if (!status.la_full) st_next = S_INS_SET;
                    lteb_pkg::K_ENTER: if (!status.lines_full) st_next = S_SPL_SET;
                    lteb_pkg::K_BS: begin
                        if (status.col_gt0) begin
                            st_next = S_BSD_SET;
                        end else if (status.row_gt0) begin
                            cmd     = lteb_pkg::C_RDL_ROWM1;
                            st_next = S_GETB_BS;
                        end
                    end
                    lteb_pkg::K_DEL: begin
                        if (status.col_lt_la) begin
                            st_next = S_DLD_SET;
                        end else if (status.row_next) begin
                            cmd     = lteb_pkg::C_RDL_ROWP1;
                            st_next = S_GETB_DEL;
                        end
                    end
                    lteb_pkg::K_UP: if (status.row_gt0) begin
                        cmd     = lteb_pkg::C_ROW_DEC;
                        st_next = S_RDC_CLAMP;
                    end
                    lteb_pkg::K_DOWN: if (status.row_next) begin
                        cmd     = lteb_pkg::C_ROW_INC;
                        st_next = S_RDC_CLAMP;
                    end
                    lteb_pkg::K_LEFT: begin
                        if (status.col_gt0) begin
                            cmd = lteb_pkg::C_COL_DEC;
                        end else if (status.row_gt0) begin
                            cmd     = lteb_pkg::C_ROW_DEC;
                            st_next = S_RDC_SETCOL;
                        end
                    end
                    lteb_pkg::K_RIGHT: begin
                        if (status.col_lt_la) begin
                            cmd = lteb_pkg::C_COL_INC;
                        end else if (status.row_next) begin
                            cmd = lteb_pkg::C_ROW_INC_COL0;
                        end
                    end
                    lteb_pkg::K_HOME: cmd = lteb_pkg::C_COL_ZERO;
                    lteb_pkg::K_END:  cmd = lteb_pkg::C_COL_LA;
                    default: ;
                endcase
            end
            S_RDC_CLAMP: begin
                cmd     = lteb_pkg::C_RDL_CUR;
                st_next = S_CLAMP;
            end
            S_CLAMP: begin
                cmd     = lteb_pkg::C_CLAMP;
                st_next = S_FOLLOW;
            end
            S_RDC_SETCOL: begin
                cmd     = lteb_pkg::C_RDL_CUR;
                st_next = S_SETCOL;
            end
            S_SETCOL: begin
                cmd     = lteb_pkg::C_SET_COL_LEN;
                st_next = S_FOLLOW;
            end
            S_INS_SET: begin
                cmd      = lteb_pkg::C_INS_SETUP;
                ret_next = S_INS_FIN;
                st_next  = S_MV_CHK;
            end
            S_MV_CHK: begin
                if (status.n_zero) begin
                    st_next = ret_reg;
                end else begin
                    cmd     = lteb_pkg::C_MV_RD;
                    st_next = S_MV_WR;
                end
            end
            S_MV_WR: begin
                cmd     = lteb_pkg::C_MV_WR;
                st_next = S_MV_CHK;
            end
            S_INS_FIN: begin
                cmd     = lteb_pkg::C_INS_FIN;
                st_next = S_FOLLOW;
            end
            S_SPL_SET: begin
                cmd     = lteb_pkg::C_SPL_SETUP;
                st_next = S_SPL_CHK;
            end
            S_SPL_CHK: begin
                if (status.spl_more) begin
                    lcr_next = S_SPL_CHK;
                    st_next  = S_LC_RD;
                end else begin
                    st_next = S_SPL_TAIL;
                end
            end
            S_LC_RD: begin
                cmd     = lteb_pkg::C_RDL_SRC;
                st_next = S_LC_SET;
            end
            S_LC_SET: begin
                cmd      = lteb_pkg::C_LC_SETUP;
                ret_next = S_LC_FIN;
                st_next  = S_MV_CHK;
            end
            S_LC_FIN: begin
                cmd     = lteb_pkg::C_LC_FIN;
                st_next = lcr_reg;
            end
            S_SPL_TAIL: begin
                cmd      = lteb_pkg::C_SPL_TAIL;
                ret_next = S_SPL_F1;
                st_next  = S_MV_CHK;
            end
            S_SPL_F1: begin
                cmd     = lteb_pkg::C_SPL_FIN1;
                st_next = S_SPL_F2;
            end
            S_SPL_F2: begin
                cmd     = lteb_pkg::C_SPL_FIN2;
                st_next = S_FOLLOW;
            end
            S_BSD_SET: begin
                cmd      = lteb_pkg::C_BSD_SETUP;
                ret_next = S_BSD_FIN;
                st_next  = S_MV_CHK;
            end
            S_BSD_FIN: begin
                cmd     = lteb_pkg::C_DROP_FIN_BS;
                st_next = S_FOLLOW;
            end
            S_DLD_SET: begin
                cmd      = lteb_pkg::C_DLD_SETUP;
                ret_next = S_DLD_FIN;
                st_next  = S_MV_CHK;
            end
            S_DLD_FIN: begin
                cmd     = lteb_pkg::C_DROP_FIN_DEL;
                st_next = S_FOLLOW;
            end
            S_GETB_BS: begin
                cmd     = lteb_pkg::C_GET_B;
                st_next = S_JBS;
            end
            S_JBS: begin
                cmd     = lteb_pkg::C_JBS_SETUP;
                st_next = S_APP_SET;
            end
            S_GETB_DEL: begin
                cmd     = lteb_pkg::C_GET_B;
                st_next = S_JDEL;
            end
            S_JDEL: begin
                cmd     = lteb_pkg::C_JDEL_SETUP;
                st_next = S_APP_SET;
            end
            S_APP_SET: begin
                cmd      = lteb_pkg::C_APP_SETUP;
                ret_next = S_APP_FIN;
                st_next  = S_MV_CHK;
            end
            S_APP_FIN: begin
                cmd     = lteb_pkg::C_APP_FIN;
                st_next = S_GAP_CHK;
            end
            S_GAP_CHK: begin
                if (status.gap_more) begin
                    lcr_next = S_GAP_CHK;
                    st_next  = S_LC_RD;
                end else begin
                    st_next = S_JFIN;
                end
            end
            S_JFIN: begin
                cmd     = (status.kind == lteb_pkg::K_BS) ? lteb_pkg::C_JOIN_FIN_BS
                                                          : lteb_pkg::C_JOIN_FIN_DEL;
                st_next = S_FOLLOW;
            end
            S_FOLLOW: begin
                cmd     = lteb_pkg::C_FOLLOW;
                st_next = S_FIN;
            end
            S_FIN: begin
                cmd     = lteb_pkg::C_RDL_CUR;
                st_next = S_OUT;
            end
            S_OUT: if (!mv_reg || m_ready) begin
                cmd     = lteb_pkg::C_OUT;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign mv_next = (cmd == lteb_pkg::C_OUT) ? 1'b1 : (mv_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            ret_reg <= S_IDLE;
            lcr_reg <= S_IDLE;
            mv_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            ret_reg <= ret_next;
            lcr_reg <= lcr_next;
            mv_reg  <= mv_next;
        end
    end

endmodule
